@@ design/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg: shared types, constants and helpers for the complex arithmetic unit
// Fixed point format, operation and status codes, pipeline stage records,
// saturation helpers and the arctangent table for the angle datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int ANGLE_ITERATIONS = 16;
  localparam int ATAN_ENTRIES     = 24;
  // quotient bits kept by the divider; anything wider saturates anyway
  localparam int QBITS            = 33;
  localparam int DIV_W            = 64 + QBITS;
  localparam int ROOT_W           = 32;
  localparam int NSTEP            = QBITS + 1;
  localparam int CW               = 36;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_NEG, OP_MAG, OP_ARG, OP_EQ
  } op_e;

  typedef enum logic [1:0] {
    ST_OK, ST_DIV0, ST_ARG0, ST_SAT
  } status_e;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } sat_t;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] ar;
    logic signed [31:0] ai;
    logic signed [31:0] br;
    logic signed [31:0] bi;
  } req_t;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] ar;
    logic signed [31:0] ai;
    logic [31:0]        re;
    logic [31:0]        im;
    logic               eq;
    logic               sat;
    logic               b_zero;
    logic signed [63:0] p_rr;
    logic signed [63:0] p_ii;
    logic signed [63:0] p_ir;
    logic signed [63:0] p_ri;
    logic signed [63:0] p_br;
    logic signed [63:0] p_bi;
    logic signed [63:0] p_ar;
    logic signed [63:0] p_ai;
  } prod_t;

  typedef struct packed {
    op_e                 op;
    logic [31:0]         re;
    logic [31:0]         im;
    logic                eq;
    logic                sat;
    logic signed [64:0]  mre;
    logic signed [64:0]  mim;
    logic [63:0]         den;
    logic                den_zero;
    logic                neg_re;
    logic                neg_im;
    logic [DIV_W-1:0]    rem_re;
    logic [DIV_W-1:0]    rem_im;
    logic [QBITS-1:0]    q_re;
    logic [QBITS-1:0]    q_im;
    logic                ovf_re;
    logic                ovf_im;
    logic [63:0]         srem;
    logic [ROOT_W-1:0]   root;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [31:0]  cz;
    logic                a_zero;
  } stage_t;

  localparam logic [31:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  localparam logic [31:0] HALF_PI_Q30 = 32'h6487ED51;

  // round a 2^-30 angle to the working fraction
  function automatic logic signed [31:0] ang_c(input logic [31:0] t30);
    logic [32:0] s;
    s = {1'b0, t30} + (33'd1 << (29 - FRAC_BITS));
    return $signed(32'(s >> (30 - FRAC_BITS)));
  endfunction

  // clamp a wide signed value to 32 bits
  function automatic sat_t sat_s(input logic signed [64:0] v);
    sat_t r;
    if (v > 65'sd2147483647) begin
      r.val = 32'h7FFFFFFF;
      r.sat = 1'b1;
    end else if (v < -65'sd2147483648) begin
      r.val = 32'h80000000;
      r.sat = 1'b1;
    end else begin
      r.val = v[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  // apply sign to a quotient magnitude and clamp
  function automatic sat_t div_val(input logic neg, input logic [QBITS-1:0] q,
                                   input logic ovf);
    logic signed [64:0] v;
    if (ovf) begin
      v = neg ? -(65'sd1 <<< 40) : (65'sd1 <<< 40);
    end else begin
      v = neg ? -$signed({{(65-QBITS){1'b0}}, q}) : $signed({{(65-QBITS){1'b0}}, q});
    end
    return sat_s(v);
  endfunction

endpackage

`default_nettype wire

@@ design/cau_front.sv @@
// ----------------------------------------------------------------------------
// cau_front: request capture, products and sums
// Three stages: register the request, form all partial products together
// with the simple operations, then form the sums that seed the iterative
// stages.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic            req_valid,
  input  wire cau_pkg::req_t   req,
  output logic                 stg_valid,
  output cau_pkg::stage_t      stg
);

  cau_pkg::req_t   req_r;
  cau_pkg::prod_t  prod_r, prod_nxt;
  cau_pkg::stage_t stg_r, stg_nxt;
  logic [2:0]      vld_r;

  // advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[1:0], req_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      req_r  <= req;
      prod_r <= prod_nxt;
      stg_r  <= stg_nxt;
    end
  end

  // products and the one-step operations
  always_comb begin
    cau_pkg::sat_t      s_re, s_im;
    logic signed [64:0] are, aim, bre, bim;
    are = {{33{req_r.ar[31]}}, req_r.ar};
    aim = {{33{req_r.ai[31]}}, req_r.ai};
    bre = {{33{req_r.br[31]}}, req_r.br};
    bim = {{33{req_r.bi[31]}}, req_r.bi};
    prod_nxt.op     = req_r.op;
    prod_nxt.ar     = req_r.ar;
    prod_nxt.ai     = req_r.ai;
    prod_nxt.b_zero = (req_r.br == 32'sd0) && (req_r.bi == 32'sd0);
    prod_nxt.eq     = 1'b0;
    prod_nxt.p_rr   = req_r.ar * req_r.br;
    prod_nxt.p_ii   = req_r.ai * req_r.bi;
    prod_nxt.p_ir   = req_r.ai * req_r.br;
    prod_nxt.p_ri   = req_r.ar * req_r.bi;
    prod_nxt.p_br   = req_r.br * req_r.br;
    prod_nxt.p_bi   = req_r.bi * req_r.bi;
    prod_nxt.p_ar   = req_r.ar * req_r.ar;
    prod_nxt.p_ai   = req_r.ai * req_r.ai;
    s_re = '0;
    s_im = '0;
    case (req_r.op)
      cau_pkg::OP_ADD: begin
        s_re = cau_pkg::sat_s(are + bre);
        s_im = cau_pkg::sat_s(aim + bim);
      end
      cau_pkg::OP_SUB: begin
        s_re = cau_pkg::sat_s(are - bre);
        s_im = cau_pkg::sat_s(aim - bim);
      end
      cau_pkg::OP_NEG: begin
        s_re = cau_pkg::sat_s(-are);
        s_im = cau_pkg::sat_s(-aim);
      end
      cau_pkg::OP_EQ: begin
        prod_nxt.eq = (req_r.ar == req_r.br) && (req_r.ai == req_r.bi);
      end
      default: begin
        s_re = '0;
      end
    endcase
    prod_nxt.re  = s_re.val;
    prod_nxt.im  = s_im.val;
    prod_nxt.sat = s_re.sat | s_im.sat;
  end

  // sums of products; seed the divider, root and angle datapaths
  always_comb begin
    logic signed [64:0] dre, dim;
    logic [63:0]        mag_re, mag_im;
    dre = 65'(prod_r.p_rr) + 65'(prod_r.p_ii);
    dim = 65'(prod_r.p_ir) - 65'(prod_r.p_ri);
    mag_re = dre[64] ? 64'(-dre) : dre[63:0];
    mag_im = dim[64] ? 64'(-dim) : dim[63:0];
    stg_nxt          = '0;
    stg_nxt.op       = prod_r.op;
    stg_nxt.re       = prod_r.re;
    stg_nxt.im       = prod_r.im;
    stg_nxt.eq       = prod_r.eq;
    stg_nxt.sat      = prod_r.sat;
    stg_nxt.mre      = 65'(prod_r.p_rr) - 65'(prod_r.p_ii);
    stg_nxt.mim      = 65'(prod_r.p_ir) + 65'(prod_r.p_ri);
    stg_nxt.den      = $unsigned(prod_r.p_br) + $unsigned(prod_r.p_bi);
    stg_nxt.den_zero = prod_r.b_zero;
    stg_nxt.neg_re   = dre[64];
    stg_nxt.neg_im   = dim[64];
    stg_nxt.rem_re   = cau_pkg::DIV_W'(mag_re) << cau_pkg::FRAC_BITS;
    stg_nxt.rem_im   = cau_pkg::DIV_W'(mag_im) << cau_pkg::FRAC_BITS;
    stg_nxt.srem     = $unsigned(prod_r.p_ar) + $unsigned(prod_r.p_ai);
    stg_nxt.cx       = cau_pkg::CW'(prod_r.ar);
    stg_nxt.cy       = cau_pkg::CW'(prod_r.ai);
    stg_nxt.a_zero   = (prod_r.ar == 32'sd0) && (prod_r.ai == 32'sd0);
  end

  assign stg_valid = vld_r[2];
  assign stg       = stg_r;

endmodule

`default_nettype wire

@@ design/cau_chain.sv @@
// ----------------------------------------------------------------------------
// cau_chain: iterative datapaths unrolled into pipeline stages
// Stages 1-33 each retire one quotient bit on both divider lanes, stages 0-31
// one root bit and stages 1-16 one vectoring rotation. Stage 0 checks quotient
// overflow, rounds the multiply and pre-rotates the angle vector.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_chain (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             adv,
  input  wire logic             in_vld,
  input  wire cau_pkg::stage_t  in_stg,
  output logic                  out_vld,
  output cau_pkg::stage_t       out_stg
);

  cau_pkg::stage_t              stg_r   [cau_pkg::NSTEP];
  cau_pkg::stage_t              stg_nxt [cau_pkg::NSTEP];
  logic [cau_pkg::NSTEP-1:0]    vld_r;

  // advance valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[cau_pkg::NSTEP-2:0], in_vld};
    end
  end

  for (genvar j = 0; j < cau_pkg::NSTEP; j++) begin : g_step
    localparam int KD = (j >= 1) ? cau_pkg::QBITS - j : 0;
    localparam int KS = (j < cau_pkg::ROOT_W) ? cau_pkg::ROOT_W - 1 - j : 0;
    localparam int KC = (j >= 1) ? j - 1 : 0;
    localparam bit DO_ROT = (j >= 1) && (j <= cau_pkg::ANGLE_ITERATIONS) &&
                            (j <= cau_pkg::ATAN_ENTRIES);

    cau_pkg::stage_t cur;

    if (j == 0) begin : g_first
      assign cur = in_stg;
    end else begin : g_rest
      assign cur = stg_r[j-1];
    end

    always_comb begin
      cau_pkg::sat_t          m_re, m_im;
      logic [cau_pkg::DIV_W-1:0] dsh;
      logic [64:0]            trial;
      logic signed [cau_pkg::CW-1:0] dx, dy;
      logic signed [31:0]     half;
      stg_nxt[j] = cur;
      dsh   = cau_pkg::DIV_W'(cur.den) << KD;
      trial = (65'(cur.root) << (KS + 1)) + (65'd1 << (2 * KS));
      dx    = cur.cy >>> KC;
      dy    = cur.cx >>> KC;
      half  = cau_pkg::ang_c(cau_pkg::HALF_PI_Q30);
      m_re  = cau_pkg::sat_s(cur.mre >>> cau_pkg::FRAC_BITS);
      m_im  = cau_pkg::sat_s(cur.mim >>> cau_pkg::FRAC_BITS);

      if (j == 0) begin
        // quotient too wide for the lanes
        stg_nxt[j].ovf_re = cur.rem_re >= {cur.den, {cau_pkg::QBITS{1'b0}}};
        stg_nxt[j].ovf_im = cur.rem_im >= {cur.den, {cau_pkg::QBITS{1'b0}}};
        // round the product toward minus infinity and clamp
        if (cur.op == cau_pkg::OP_MUL) begin
          stg_nxt[j].re  = m_re.val;
          stg_nxt[j].im  = m_im.val;
          stg_nxt[j].sat = m_re.sat | m_im.sat;
        end
        // bring the vector into the right half plane
        if (cur.cx < 0) begin
          if (cur.cy >= 0) begin
            stg_nxt[j].cx = cur.cy;
            stg_nxt[j].cy = -cur.cx;
            stg_nxt[j].cz = half;
          end else begin
            stg_nxt[j].cx = -cur.cy;
            stg_nxt[j].cy = cur.cx;
            stg_nxt[j].cz = -half;
          end
        end
      end else begin
        // one restoring divide step on each lane
        if (cur.rem_re >= dsh) begin
          stg_nxt[j].rem_re   = cur.rem_re - dsh;
          stg_nxt[j].q_re[KD] = 1'b1;
        end
        if (cur.rem_im >= dsh) begin
          stg_nxt[j].rem_im   = cur.rem_im - dsh;
          stg_nxt[j].q_im[KD] = 1'b1;
        end
      end

      // one root bit
      if (j < cau_pkg::ROOT_W) begin
        if (65'(cur.srem) >= trial) begin
          stg_nxt[j].srem     = cur.srem - trial[63:0];
          stg_nxt[j].root[KS] = 1'b1;
        end
      end

      // one vectoring rotation
      if (DO_ROT) begin
        if (cur.cy > 0) begin
          stg_nxt[j].cx = cur.cx + dx;
          stg_nxt[j].cy = cur.cy - dy;
          stg_nxt[j].cz = cur.cz + cau_pkg::ang_c(cau_pkg::ATAN_Q30[KC]);
        end else begin
          stg_nxt[j].cx = cur.cx - dx;
          stg_nxt[j].cy = cur.cy + dy;
          stg_nxt[j].cz = cur.cz - cau_pkg::ang_c(cau_pkg::ATAN_Q30[KC]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg_r[j] <= stg_nxt[j];
      end
    end
  end

  assign out_vld = vld_r[cau_pkg::NSTEP-1];
  assign out_stg = stg_r[cau_pkg::NSTEP-1];

endmodule

`default_nettype wire

@@ design/cau_back.sv @@
// ----------------------------------------------------------------------------
// cau_back: result selection and output register
// Picks the result of the requested operation, folds in the status and
// holds it until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic            stg_vld,
  input  wire cau_pkg::stage_t stg,
  output logic                 res_valid,
  output logic [31:0]          res_re,
  output logic [31:0]          res_im,
  output logic                 res_eq,
  output logic [1:0]           res_status
);

  logic               valid_r;
  logic [31:0]        re_r, re_nxt;
  logic [31:0]        im_r, im_nxt;
  logic               eq_r, eq_nxt;
  cau_pkg::status_e   st_r, st_nxt;

  // select per operation
  always_comb begin
    cau_pkg::sat_t   d_re, d_im, mag;
    cau_pkg::status_e code;
    logic            sat;
    d_re = cau_pkg::div_val(stg.neg_re, stg.q_re, stg.ovf_re);
    d_im = cau_pkg::div_val(stg.neg_im, stg.q_im, stg.ovf_im);
    mag  = cau_pkg::sat_s(65'(stg.root));
    re_nxt = stg.re;
    im_nxt = stg.im;
    eq_nxt = stg.eq;
    sat    = stg.sat;
    code   = cau_pkg::ST_OK;
    case (stg.op)
      cau_pkg::OP_DIV: begin
        if (stg.den_zero) begin
          re_nxt = '0;
          im_nxt = '0;
          code   = cau_pkg::ST_DIV0;
        end else begin
          re_nxt = d_re.val;
          im_nxt = d_im.val;
          sat    = d_re.sat | d_im.sat;
        end
      end
      cau_pkg::OP_MAG: begin
        re_nxt = mag.val;
        im_nxt = '0;
        sat    = mag.sat;
      end
      cau_pkg::OP_ARG: begin
        im_nxt = '0;
        if (stg.a_zero) begin
          re_nxt = '0;
          code   = cau_pkg::ST_ARG0;
        end else begin
          re_nxt = stg.cz;
        end
      end
      default: begin
        code = cau_pkg::ST_OK;
      end
    endcase
    st_nxt = sat ? cau_pkg::ST_SAT : code;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= stg_vld;
    end
  end

  // hold the result while the consumer stalls
  always_ff @(posedge clk) begin
    if (adv) begin
      re_r <= re_nxt;
      im_r <= im_nxt;
      eq_r <= eq_nxt;
      st_r <= st_nxt;
    end
  end

  assign res_valid  = valid_r;
  assign res_re     = re_r;
  assign res_im     = im_r;
  assign res_eq     = eq_r;
  assign res_status = st_r;

endmodule

`default_nettype wire

@@ design/complex_arithmetic_unit_top.sv @@
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top: pipelined complex arithmetic in Q16.16
// Add, subtract, multiply, divide, negate, magnitude, argument and equality
// on two complex operands, with saturation and error status.
//
//   channel   direction  handshake            payload
//   in_       request    in_valid / in_stall  req_type, a_re, a_im, b_re, b_im
//   out_      result     out_valid / out_stall res_re, res_im, is_equal, status
//
// One request per cycle while in_stall is low; each result passes through
// three front stages, 34 stages of the unrolled divider, root and angle
// datapaths (set by the 33 quotient bits plus the overflow check), and the
// output register. Reset (synchronous, rst_n low) empties the pipeline.
// A stall on the result side freezes every stage; in_stall follows it.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_req_type,
  input  wire logic signed [31:0] in_a_re,
  input  wire logic signed [31:0] in_a_im,
  input  wire logic signed [31:0] in_b_re,
  input  wire logic signed [31:0] in_b_im,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_res_re,
  output logic signed [31:0]      out_res_im,
  output logic                    out_is_equal,
  output logic [1:0]              out_status
);

  logic            adv;
  cau_pkg::req_t   req;
  logic            f_vld, c_vld;
  cau_pkg::stage_t f_stg, c_stg;
  logic [31:0]     re, im;

  // advance unless a finished result is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  assign req.op = cau_pkg::op_e'(in_req_type);
  assign req.ar = in_a_re;
  assign req.ai = in_a_im;
  assign req.br = in_b_re;
  assign req.bi = in_b_im;

  cau_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .req_valid (in_valid),
    .req       (req),
    .stg_valid (f_vld),
    .stg       (f_stg)
  );

  cau_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (f_vld),
    .in_stg  (f_stg),
    .out_vld (c_vld),
    .out_stg (c_stg)
  );

  cau_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .stg_vld    (c_vld),
    .stg        (c_stg),
    .res_valid  (out_valid),
    .res_re     (re),
    .res_im     (im),
    .res_eq     (out_is_equal),
    .res_status (out_status)
  );

  assign out_res_re = $signed(re);
  assign out_res_im = $signed(im);

endmodule

`default_nettype wire

@@ tb/complex_arithmetic_unit_top_test.sv @@
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top_test: self-checking bench for the complex unit
// Drives directed corner requests, then random requests with random gaps and
// output stalls, and a long output hold-off that backs up the pipeline. Every
// result is checked field by field against an in-bench fixed point predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit_top_test;

  typedef logic signed [71:0] wide_t;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        eq;
    logic [1:0]  st;
  } cplx_res_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         in_req_type;
  logic signed [31:0] in_a_re, in_a_im, in_b_re, in_b_im;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_res_re, out_res_im;
  logic               out_is_equal;
  logic [1:0]         out_status;

  cplx_res_t pending_results[$];
  int        err_cnt;
  int        tx_max_gap;
  int        rx_hold_cycles;
  bit        rx_quiet;

  complex_arithmetic_unit_top u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_a_re      (in_a_re),
    .in_a_im      (in_a_im),
    .in_b_re      (in_b_re),
    .in_b_im      (in_b_im),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_res_re   (out_res_re),
    .out_res_im   (out_res_im),
    .out_is_equal (out_is_equal),
    .out_status   (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // clamp a sign-magnitude value to 32 bits
  function automatic logic [31:0] clamp_sm(input logic neg, input logic [127:0] mag,
                                           inout logic sat);
    if (!neg) begin
      if (mag > 128'h7FFFFFFF) begin
        sat = 1'b1;
        return 32'h7FFFFFFF;
      end
      return mag[31:0];
    end
    if (mag > 128'h80000000) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return 32'd0 - mag[31:0];
  endfunction

  function automatic logic [31:0] clamp_w(input wide_t v, inout logic sat);
    wide_t m;
    m = (v < 0) ? -v : v;
    return clamp_sm(v < 0, 128'(m), sat);
  endfunction

  // floor((|num| << FRAC_BITS) / den), sign of num, then clamp
  function automatic logic [31:0] fx_quot(input wide_t num, input logic [63:0] den,
                                          inout logic sat);
    logic [127:0] m;
    wide_t a;
    a = (num < 0) ? -num : num;
    m = (128'(a) << cau_pkg::FRAC_BITS) / 128'(den);
    return clamp_sm(num < 0 && m != 0, m, sat);
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] s);
    logic [63:0] res, b;
    res = 64'd0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint angle_const(input logic [31:0] t30);
    return (longint'({32'd0, t30}) + (longint'(1) << (29 - cau_pkg::FRAC_BITS)))
           >>> (30 - cau_pkg::FRAC_BITS);
  endfunction

  // vectoring CORDIC after a quarter-turn into the right half plane
  function automatic longint arg_angle(input longint x, input longint y);
    longint z, t, dx, dy;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = angle_const(cau_pkg::HALF_PI_Q30);
      end else begin
        x = -y;
        y = t;
        z = -angle_const(cau_pkg::HALF_PI_Q30);
      end
    end
    for (int i = 0; i < cau_pkg::ANGLE_ITERATIONS && i < cau_pkg::ATAN_ENTRIES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + angle_const(cau_pkg::ATAN_Q30[i]);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - angle_const(cau_pkg::ATAN_Q30[i]);
      end
    end
    return z;
  endfunction

  function automatic cplx_res_t predict_cplx(input cau_pkg::op_e op,
                                             input logic signed [31:0] ar,
                                             input logic signed [31:0] ai,
                                             input logic signed [31:0] br,
                                             input logic signed [31:0] bi);
    cplx_res_t r;
    wide_t war, wai, wbr, wbi, s;
    logic [63:0] den;
    logic sat;
    war = ar; wai = ai; wbr = br; wbi = bi;
    r = '{re: '0, im: '0, eq: 1'b0, st: cau_pkg::ST_OK};
    sat = 1'b0;
    case (op)
      cau_pkg::OP_ADD: begin
        r.re = clamp_w(war + wbr, sat);
        r.im = clamp_w(wai + wbi, sat);
      end
      cau_pkg::OP_SUB: begin
        r.re = clamp_w(war - wbr, sat);
        r.im = clamp_w(wai - wbi, sat);
      end
      cau_pkg::OP_MUL: begin
        s = war * wbr - wai * wbi;
        r.re = clamp_w(s >>> cau_pkg::FRAC_BITS, sat);
        s = wai * wbr + war * wbi;
        r.im = clamp_w(s >>> cau_pkg::FRAC_BITS, sat);
      end
      cau_pkg::OP_DIV: begin
        if (br == 0 && bi == 0) begin
          r.st = cau_pkg::ST_DIV0;
        end else begin
          den = 64'(wbr * wbr + wbi * wbi);
          r.re = fx_quot(war * wbr + wai * wbi, den, sat);
          r.im = fx_quot(wai * wbr - war * wbi, den, sat);
        end
      end
      cau_pkg::OP_NEG: begin
        r.re = clamp_w(-war, sat);
        r.im = clamp_w(-wai, sat);
      end
      cau_pkg::OP_MAG: begin
        r.re = clamp_sm(1'b0, 128'(int_sqrt(64'(war * war + wai * wai))), sat);
      end
      cau_pkg::OP_ARG: begin
        if (ar == 0 && ai == 0) r.st = cau_pkg::ST_ARG0;
        else r.re = clamp_w(wide_t'(arg_angle(longint'(ar), longint'(ai))), sat);
      end
      default: begin
        r.eq = (ar == br && ai == bi);
      end
    endcase
    if (sat) r.st = cau_pkg::ST_SAT;
    return r;
  endfunction

  // offer one request after a random gap; record its result once accepted
  task automatic send_req(input cau_pkg::op_e op, input logic [31:0] ar,
                          input logic [31:0] ai, input logic [31:0] br,
                          input logic [31:0] bi);
    int gap;
    gap = 0;
    if (tx_max_gap > 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, tx_max_gap)
                                        : $urandom_range(0, 2);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    = 1'b1;
    in_req_type = op;
    in_a_re     = ar;
    in_a_im     = ai;
    in_b_re     = br;
    in_b_im     = bi;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_cplx(op, ar, ai, br, bi));
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 32'd0;
      3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hFFFF0000;
      4, 5: return 32'($signed($urandom_range(0, 32'h0007FFFF)) - 32'sh00040000);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    // extremes, every operation and each error path
    send_req(cau_pkg::OP_ADD, 32'h7FFFFFFF, 32'h80000000, 32'h00000001, 32'hFFFFFFFF);
    send_req(cau_pkg::OP_ADD, 32'h00018000, 32'hFFFE0000, 32'h00008000, 32'h00030000);
    send_req(cau_pkg::OP_SUB, 32'h80000000, 32'h7FFFFFFF, 32'h00000001, 32'hFFFFFFFF);
    send_req(cau_pkg::OP_SUB, 32'h00050000, 32'h00020000, 32'h00010000, 32'h00030000);
    send_req(cau_pkg::OP_MUL, 32'h00020000, 32'h00030000, 32'h00040000, 32'hFFFB0000);
    send_req(cau_pkg::OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_req(cau_pkg::OP_MUL, 32'hFFFFFFFF, 32'h00000000, 32'h00000001, 32'h00000000);
    send_req(cau_pkg::OP_DIV, 32'h00010000, 32'h00020000, 32'h00000000, 32'h00000000);
    send_req(cau_pkg::OP_DIV, 32'h00030000, 32'h00040000, 32'h00010000, 32'hFFFF0000);
    send_req(cau_pkg::OP_DIV, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00000001, 32'h00000000);
    send_req(cau_pkg::OP_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send_req(cau_pkg::OP_DIV, 32'hFFFFFFFF, 32'h00000001, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_req(cau_pkg::OP_NEG, 32'h80000000, 32'h00010000, 32'h0, 32'h0);
    send_req(cau_pkg::OP_NEG, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0);
    send_req(cau_pkg::OP_MAG, 32'h00030000, 32'h00040000, 32'h0, 32'h0);
    send_req(cau_pkg::OP_MAG, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
    send_req(cau_pkg::OP_MAG, 32'h7FFFFFFF, 32'h00000000, 32'h0, 32'h0);
    send_req(cau_pkg::OP_ARG, 32'h00000000, 32'h00000000, 32'h0, 32'h0);
    send_req(cau_pkg::OP_ARG, 32'hFFFF0000, 32'h00000000, 32'h0, 32'h0);
    send_req(cau_pkg::OP_ARG, 32'hFFFF0000, 32'hFFFFFFFF, 32'h0, 32'h0);
    send_req(cau_pkg::OP_ARG, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0);
    send_req(cau_pkg::OP_ARG, 32'h00000000, 32'h80000000, 32'h0, 32'h0);
    send_req(cau_pkg::OP_EQ,  32'h12345678, 32'h80000000, 32'h12345678, 32'h80000000);
    send_req(cau_pkg::OP_EQ,  32'h12345678, 32'h80000000, 32'h12345678, 32'h80000001);
  endtask

  task automatic test_random(input int count);
    logic [31:0] ar, ai, br, bi;
    for (int n = 0; n < count; n++) begin
      rx_quiet   = (n % 100) >= 80;
      tx_max_gap = rx_quiet ? 0 : 30;
      ar = rand_operand();
      ai = rand_operand();
      br = rand_operand();
      bi = rand_operand();
      case ($urandom_range(0, 9))
        0: begin
          br = ar;
          bi = ai;
        end
        1: begin
          br = 32'd0;
          bi = 32'd0;
        end
        2: begin
          ar = 32'd0;
          ai = 32'd0;
        end
        default: ;
      endcase
      send_req(cau_pkg::op_e'($urandom_range(0, 7)), ar, ai, br, bi);
    end
    rx_quiet   = 1'b0;
    tx_max_gap = 30;
  endtask

  // hold the result side off while requests keep coming, to back up the pipe
  task automatic test_backpressure();
    tx_max_gap     = 0;
    rx_hold_cycles = 150;
    for (int n = 0; n < 80; n++) begin
      send_req(cau_pkg::op_e'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
               $urandom);
    end
    tx_max_gap = 30;
  endtask

  // result side stall pattern
  initial begin
    int stall_left;
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_stall = 1'b1;
        rx_hold_cycles--;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
        out_stall  = 1'b1;
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    cplx_res_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result re=%h im=%h eq=%b st=%0d", $time,
                 out_res_re, out_res_im, out_is_equal, out_status);
        err_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_res_re !== exp_r.re) begin
          $display("%0t: res_re expected %h actual %h", $time, exp_r.re, out_res_re);
          err_cnt++;
        end
        if (out_res_im !== exp_r.im) begin
          $display("%0t: res_im expected %h actual %h", $time, exp_r.im, out_res_im);
          err_cnt++;
        end
        if (out_is_equal !== exp_r.eq) begin
          $display("%0t: is_equal expected %b actual %b", $time, exp_r.eq, out_is_equal);
          err_cnt++;
        end
        if (out_status !== exp_r.st) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.st, out_status);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    err_cnt        = 0;
    tx_max_gap     = 30;
    rx_hold_cycles = 0;
    rx_quiet       = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = cau_pkg::OP_ADD;
    in_a_re        = '0;
    in_a_im        = '0;
    in_b_re        = '0;
    in_b_im        = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(200);
    test_backpressure();
    test_random(200);

    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (60) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
